### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the quaternion-to-matrix core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent checked after the delay given by dly
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// Widths, entry indexes and types shared by the quaternion-to-matrix core.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int IN_W          = 16;
    localparam int OUT_W         = 16;
    localparam int PROD_W        = 32;
    localparam int SUM_W         = 33;
    localparam int N_W           = 33;
    localparam int LO_W          = 32;
    localparam int ACC_W         = 64;
    localparam int DROP          = 31;
    localparam int N_ENT         = 9;
    localparam int OUT_MAX       = 32767;
    localparam int OUT_MIN       = -32768;
    localparam int FRAC_BITS_DEF = 14;

    localparam int E00 = 0;
    localparam int E01 = 1;
    localparam int E02 = 2;
    localparam int E10 = 3;
    localparam int E11 = 4;
    localparam int E12 = 5;
    localparam int E20 = 6;
    localparam int E21 = 7;
    localparam int E22 = 8;

    // entries of the form 1 - sum*s
    localparam logic [N_ENT-1:0] DIAG_MASK = 9'b100010001;

    typedef logic signed [IN_W-1:0]     t_fix;
    typedef logic [N_ENT-1:0][SUM_W-1:0] t_terms;
    typedef logic [N_ENT-1:0][OUT_W-1:0] t_mat;

endpackage

### hw/rtl/quaternion_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core
// Quaternion (x, y, z, w) in signed Q1.FRAC_BITS to the nine entries of its
// 3x3 rotation matrix, normalised through a rounded reciprocal of the squared norm.
//
// Input: a word is taken at each rising edge with start high and busy low.
// busy is low in normal running, so a new word may follow every cycle.
// Output: o_valid marks each result for exactly one cycle, o_m00..o_m22
// alongside it. Results leave in input order, one per input word.
// Pipeline: FRAC_BITS+38 register stages, namely two product/sum stages,
// FRAC_BITS+33 divider stages (one quotient bit each), two multiply stages
// and a round/saturate stage. Throughput: one word per cycle while busy is
// low.
// Reset: synchronous; clears all valid bits, so words in flight are
// dropped. busy is high during reset and is cleared at the first edge after it.
// The receiver has no stall: each result is shown once and must be taken.
// A zero quaternion gives the identity matrix.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_to_rotation_matrix_core #(
    parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  qrm_pkg::t_fix i_qx,
    input  qrm_pkg::t_fix i_qy,
    input  qrm_pkg::t_fix i_qz,
    input  qrm_pkg::t_fix i_qw,
    output logic          o_valid,
    output qrm_pkg::t_fix o_m00,
    output qrm_pkg::t_fix o_m01,
    output qrm_pkg::t_fix o_m02,
    output qrm_pkg::t_fix o_m10,
    output qrm_pkg::t_fix o_m11,
    output qrm_pkg::t_fix o_m12,
    output qrm_pkg::t_fix o_m20,
    output qrm_pkg::t_fix o_m21,
    output qrm_pkg::t_fix o_m22
);
    import qrm_pkg::*;

    localparam int LAT    = FRAC_BITS + 38;
    localparam int UNIT_I = (FRAC_BITS >= OUT_W - 1) ? OUT_MAX : (1 << FRAC_BITS);
    localparam t_fix UNIT = OUT_W'(UNIT_I);

    logic           r_busy;
    logic           w_accept;
    logic           w_p_valid;
    logic [N_W-1:0] w_p_n;
    t_terms         w_p_terms;
    logic           w_r_valid;
    logic [FRAC_BITS+32:0] w_recip;
    t_terms         w_r_terms;
    t_mat           w_mat;
    logic           w_zero_in;
    logic           w_ident;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    qrm_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_qx    (i_qx),
        .i_qy    (i_qy),
        .i_qz    (i_qz),
        .i_qw    (i_qw),
        .o_valid (w_p_valid),
        .o_n     (w_p_n),
        .o_terms (w_p_terms)
    );

    qrm_recip #(
        .FRAC_BITS (FRAC_BITS)
    ) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_p_valid),
        .i_n     (w_p_n),
        .i_terms (w_p_terms),
        .o_valid (w_r_valid),
        .o_recip (w_recip),
        .o_terms (w_r_terms)
    );

    qrm_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_r_valid),
        .i_recip (w_recip),
        .i_terms (w_r_terms),
        .o_valid (o_valid),
        .o_mat   (w_mat)
    );

    assign o_m00 = w_mat[E00];
    assign o_m01 = w_mat[E01];
    assign o_m02 = w_mat[E02];
    assign o_m10 = w_mat[E10];
    assign o_m11 = w_mat[E11];
    assign o_m12 = w_mat[E12];
    assign o_m20 = w_mat[E20];
    assign o_m21 = w_mat[E21];
    assign o_m22 = w_mat[E22];

    assign w_zero_in = w_accept && i_qx == '0 && i_qy == '0 && i_qz == '0 && i_qw == '0;
    assign w_ident   = o_m00 == UNIT && o_m11 == UNIT && o_m22 == UNIT
                    && o_m01 == '0 && o_m12 == '0 && o_m20 == '0;

    `ASSERT_DELAY(a_word_out, i_clk, i_rst_n, w_accept, LAT, o_valid)
    `ASSERT_IMPL(a_no_spurious, i_clk, i_rst_n, o_valid, $past(w_accept, LAT))
    `ASSERT_DELAY(a_zero_ident, i_clk, i_rst_n, w_zero_in, LAT, w_ident)

endmodule

### hw/rtl/qrm_prod.sv
// ----------------------------------------------------------------------------
// qrm_prod
// Two stages: component products, then the squared norm and the nine
// signed product sums that each matrix entry scales.
// ----------------------------------------------------------------------------
module qrm_prod (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  qrm_pkg::t_fix          i_qx,
    input  qrm_pkg::t_fix          i_qy,
    input  qrm_pkg::t_fix          i_qz,
    input  qrm_pkg::t_fix          i_qw,
    output logic                   o_valid,
    output logic [qrm_pkg::N_W-1:0] o_n,
    output qrm_pkg::t_terms        o_terms
);
    import qrm_pkg::*;

    typedef logic signed [PROD_W-1:0] t_prod;

    logic   r_va;
    logic   r_vb;
    t_prod  r_xx, r_yy, r_zz, r_ww;
    t_prod  r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic [N_W-1:0] r_n;
    logic [N_W-1:0] n_n;
    t_terms r_terms;
    t_terms n_terms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx <= PROD_W'(i_qx) * PROD_W'(i_qx);
        r_yy <= PROD_W'(i_qy) * PROD_W'(i_qy);
        r_zz <= PROD_W'(i_qz) * PROD_W'(i_qz);
        r_ww <= PROD_W'(i_qw) * PROD_W'(i_qw);
        r_xy <= PROD_W'(i_qx) * PROD_W'(i_qy);
        r_xz <= PROD_W'(i_qx) * PROD_W'(i_qz);
        r_yz <= PROD_W'(i_qy) * PROD_W'(i_qz);
        r_wx <= PROD_W'(i_qw) * PROD_W'(i_qx);
        r_wy <= PROD_W'(i_qw) * PROD_W'(i_qy);
        r_wz <= PROD_W'(i_qw) * PROD_W'(i_qz);
    end

    always_comb begin
        n_n = N_W'(r_xx) + N_W'(r_yy) + N_W'(r_zz) + N_W'(r_ww);
        n_terms[E00] = SUM_W'(r_yy) + SUM_W'(r_zz);
        n_terms[E01] = SUM_W'(r_xy) - SUM_W'(r_wz);
        n_terms[E02] = SUM_W'(r_xz) + SUM_W'(r_wy);
        n_terms[E10] = SUM_W'(r_xy) + SUM_W'(r_wz);
        n_terms[E11] = SUM_W'(r_xx) + SUM_W'(r_zz);
        n_terms[E12] = SUM_W'(r_yz) - SUM_W'(r_wx);
        n_terms[E20] = SUM_W'(r_xz) - SUM_W'(r_wy);
        n_terms[E21] = SUM_W'(r_yz) + SUM_W'(r_wx);
        n_terms[E22] = SUM_W'(r_xx) + SUM_W'(r_yy);
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_terms <= n_terms;
    end

    assign o_valid = r_vb;
    assign o_n     = r_n;
    assign o_terms = r_terms;

endmodule

### hw/rtl/qrm_recip.sv
// ----------------------------------------------------------------------------
// qrm_recip
// Pipelined restoring divider, one quotient bit per stage, giving
// round(2^(FRAC_BITS+32) / n); a zero norm gives zero. Product sums ride
// alongside.
// ----------------------------------------------------------------------------
module qrm_recip #(
    parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [qrm_pkg::N_W-1:0] i_n,
    input  qrm_pkg::t_terms         i_terms,
    output logic                    o_valid,
    output logic [FRAC_BITS+32:0]   o_recip,
    output qrm_pkg::t_terms         o_terms
);
    import qrm_pkg::*;

    localparam int QW    = FRAC_BITS + 33;
    localparam int REM_W = N_W + 1;

    logic             r_vld [QW];
    logic [REM_W-1:0] r_rem [QW];
    logic [QW-1:0]    r_num [QW];
    logic [QW-1:0]    r_quo [QW];
    logic [N_W-1:0]   r_den [QW];
    t_terms           r_trm [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic             vld_in;
        logic [REM_W-1:0] rem_in;
        logic [QW-1:0]    num_in;
        logic [QW-1:0]    quo_in;
        logic [N_W-1:0]   den_in;
        t_terms           trm_in;
        logic [REM_W-1:0] rem_sh;
        logic             fits;

        if (j == 0) begin : g_head
            // dividend 2^K + floor(n/2)
            assign vld_in = i_valid;
            assign rem_in = '0;
            assign num_in = {1'b1, {FRAC_BITS{1'b0}}, i_n[N_W-1:1]};
            assign quo_in = '0;
            assign den_in = i_n;
            assign trm_in = i_terms;
        end else begin : g_body
            assign vld_in = r_vld[j-1];
            assign rem_in = r_rem[j-1];
            assign num_in = r_num[j-1];
            assign quo_in = r_quo[j-1];
            assign den_in = r_den[j-1];
            assign trm_in = r_trm[j-1];
        end

        assign rem_sh = {rem_in[REM_W-2:0], num_in[QW-1]};
        assign fits   = rem_sh >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j] <= fits ? (rem_sh - {1'b0, den_in}) : rem_sh;
            r_num[j] <= {num_in[QW-2:0], 1'b0};
            r_quo[j] <= (den_in == '0) ? '0 : {quo_in[QW-2:0], fits};
            r_den[j] <= den_in;
            r_trm[j] <= trm_in;
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_recip = r_quo[QW-1];
    assign o_terms = r_trm[QW-1];

endmodule

### hw/rtl/qrm_scale.sv
// ----------------------------------------------------------------------------
// qrm_scale
// Scales the nine product sums by the reciprocal (split 32-bit partial
// products, modulo 2^64), subtracts from one on the diagonal, rounds and
// saturates to the output format.
// ----------------------------------------------------------------------------
module qrm_scale #(
    parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [FRAC_BITS+32:0] i_recip,
    input  qrm_pkg::t_terms       i_terms,
    output logic                  o_valid,
    output qrm_pkg::t_mat         o_mat
);
    import qrm_pkg::*;

    localparam int QW    = FRAC_BITS + 33;
    localparam int F_W   = ACC_W - DROP;
    localparam logic [ACC_W-1:0] RND     = ACC_W'(1) << (DROP - 1);
    localparam logic [ACC_W-1:0] ONE_RND = (ACC_W'(1) << (FRAC_BITS + 31)) + RND;
    localparam logic signed [F_W-1:0] F_MAX = F_W'(OUT_MAX);
    localparam logic signed [F_W-1:0] F_MIN = F_W'(OUT_MIN);

    logic r_v1, r_v2, r_v3;
    logic [N_ENT-1:0][ACC_W-1:0] r_lo_p;
    logic [N_ENT-1:0][LO_W-1:0]  r_hi_p;
    logic [N_ENT-1:0][ACC_W-1:0] r_t;
    t_mat r_mat;
    t_mat n_mat;

    logic signed [SUM_W-1:0] rlo_s;
    logic [LO_W-1:0]         rhi_u;

    assign rlo_s = {1'b0, i_recip[LO_W-1:0]};
    assign rhi_u = LO_W'(i_recip[QW-1:LO_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    for (genvar e = 0; e < N_ENT; e++) begin : g_ent
        logic signed [2*SUM_W-1:0] lo_full;
        logic [LO_W-1:0]           hi_part;
        logic [ACC_W-1:0]          v;
        logic signed [F_W-1:0]     f;

        assign lo_full = $signed(i_terms[e]) * rlo_s;
        assign hi_part = i_terms[e][LO_W-1:0] * rhi_u;

        always_ff @(posedge i_clk) begin
            r_lo_p[e] <= lo_full[ACC_W-1:0];
            r_hi_p[e] <= hi_part;
            r_t[e]    <= r_lo_p[e] + {r_hi_p[e], LO_W'(0)};
        end

        if (DIAG_MASK[e]) begin : g_diag
            assign v = ONE_RND - r_t[e];
        end else begin : g_off
            assign v = r_t[e] + RND;
        end

        assign f = $signed(v[ACC_W-1:DROP]);

        always_comb begin
            if (f > F_MAX) begin
                n_mat[e] = OUT_W'(OUT_MAX);
            end else if (f < F_MIN) begin
                n_mat[e] = OUT_W'(OUT_MIN);
            end else begin
                n_mat[e] = f[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    assign o_valid = r_v3;
    assign o_mat   = r_mat;

endmodule

### sim/quaternion_to_rotation_matrix_core_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core_tb
// Drives quaternion words into the core in bursts with random gaps and checks
// all nine matrix entries of every result in order. Expected matrices come
// from a bit-exact fixed-point model of the scaled reciprocal and rounding.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import qrm_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int RECIP_SHIFT = FRAC + 32;
    localparam int LATENCY     = FRAC + 38;
    localparam int IDLE_LIMIT  = 2000;
    localparam int N_RANDOM    = 950;

    typedef struct {
        t_fix x;
        t_fix y;
        t_fix z;
        t_fix w;
        bit   drain;
    } t_quat_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_fix i_qx = '0;
    t_fix i_qy = '0;
    t_fix i_qz = '0;
    t_fix i_qw = '0;
    logic o_valid;
    t_fix o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;

    t_quat_word quat_q[$];
    t_mat       rot_q[$];
    t_quat_word next_word;
    bit         taken = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         idle_cycles = 0;
    int         errors = 0;
    t_mat       got;
    t_mat       want;

    string ENT_NAME[N_ENT] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                               "m20", "m21", "m22"};

    quaternion_to_rotation_matrix_core #(.FRAC_BITS(FRAC)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_qx    (i_qx),
        .i_qy    (i_qy),
        .i_qz    (i_qz),
        .i_qw    (i_qw),
        .o_valid (o_valid),
        .o_m00   (o_m00),
        .o_m01   (o_m01),
        .o_m02   (o_m02),
        .o_m10   (o_m10),
        .o_m11   (o_m11),
        .o_m12   (o_m12),
        .o_m20   (o_m20),
        .o_m21   (o_m21),
        .o_m22   (o_m22)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // a*b*R, wrapping at 64 bits
    function automatic logic [63:0] scaled_term(longint a, longint b, logic [63:0] r);
        logic [63:0] ab;
        ab = a * b;
        return ab * r;
    endfunction

    // round to nearest, drop DROP bits, saturate
    function automatic t_fix round_entry(logic [63:0] v);
        longint s;
        v = v + (64'd1 << (DROP - 1));
        s = $signed(v) >>> DROP;
        if (s > OUT_MAX) s = OUT_MAX;
        if (s < OUT_MIN) s = OUT_MIN;
        return t_fix'(s[OUT_W-1:0]);
    endfunction

    function automatic t_mat rotation_of(t_fix qx, t_fix qy, t_fix qz, t_fix qw);
        longint      x, y, z, w;
        logic [63:0] n, r, one;
        logic [63:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
        t_mat        m;
        x = qx;
        y = qy;
        z = qz;
        w = qw;
        n = x * x + y * y + z * z + w * w;
        r = '0;
        if (n != 0) r = ((64'd1 << RECIP_SHIFT) + (n >> 1)) / n;
        one = 64'd1 << (RECIP_SHIFT - 1);
        xx = scaled_term(x, x, r);
        yy = scaled_term(y, y, r);
        zz = scaled_term(z, z, r);
        xy = scaled_term(x, y, r);
        xz = scaled_term(x, z, r);
        yz = scaled_term(y, z, r);
        wx = scaled_term(w, x, r);
        wy = scaled_term(w, y, r);
        wz = scaled_term(w, z, r);
        m[E00] = round_entry(one - yy - zz);
        m[E01] = round_entry(xy - wz);
        m[E02] = round_entry(xz + wy);
        m[E10] = round_entry(xy + wz);
        m[E11] = round_entry(one - xx - zz);
        m[E12] = round_entry(yz - wx);
        m[E20] = round_entry(xz - wy);
        m[E21] = round_entry(yz + wx);
        m[E22] = round_entry(one - xx - yy);
        return m;
    endfunction

    task automatic push_quat(int x, int y, int z, int w, bit drain = 1'b0);
        t_quat_word q;
        q.x = t_fix'(x);
        q.y = t_fix'(y);
        q.z = t_fix'(z);
        q.w = t_fix'(w);
        q.drain = drain;
        quat_q.push_back(q);
    endtask

    function automatic t_fix pick_component(int mode);
        int ext[7] = '{-32768, 32767, 0, 16384, -16384, 1, -1};
        case (mode)
            0: return t_fix'($urandom);
            1: return t_fix'(int'($urandom_range(0, 18918)) - 9459);
            2: return t_fix'(int'($urandom_range(0, 16)) - 8);
            3: return t_fix'(ext[$urandom_range(0, 6)]);
            default: return ($urandom_range(0, 1) == 0) ? t_fix'(0) : t_fix'($urandom);
        endcase
    endfunction

    function automatic t_quat_word random_quat();
        t_quat_word q;
        int sel;
        int mode;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: mode = 0;
            3, 4, 5: mode = 1;
            6:       mode = 2;
            7, 8:    mode = 3;
            default: mode = 4;
        endcase
        q.x = pick_component(mode);
        q.y = pick_component(mode);
        q.z = pick_component(mode);
        q.w = pick_component(mode);
        // near-unit: give the scalar part the wider range
        if (mode == 1) q.w = t_fix'(int'($urandom_range(0, 32768)) - 16384);
        if (sel == 9) begin
            q.x = (($urandom_range(0, 3) == 0) ? t_fix'(0) : q.x);
            q.y = '0;
        end
        q.drain = 1'b0;
        return q;
    endfunction

    function automatic void new_burst();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)      gap_left = $urandom_range(1, 3);
        else if (r < 8) gap_left = $urandom_range(4, 20);
        else            gap_left = $urandom_range(40, 80);
        r = $urandom_range(0, 9);
        if (r < 6)      burst_left = $urandom_range(1, 6);
        else if (r < 9) burst_left = $urandom_range(7, 40);
        else            burst_left = $urandom_range(100, 250);
    endfunction

    // sender: words change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !taken) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (quat_q.size() == 0 || (quat_q[0].drain && rot_q.size() != 0)) begin
            start <= 1'b0;
        end else begin
            next_word = quat_q.pop_front();
            i_qx  <= next_word.x;
            i_qy  <= next_word.y;
            i_qz  <= next_word.z;
            i_qw  <= next_word.w;
            start <= 1'b1;
            if (burst_left > 0) burst_left--;
            else new_burst();
        end
    end

    // results first, then the word taken at this edge
    always @(posedge i_clk) begin
        taken = i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            got[E00] = o_m00;
            got[E01] = o_m01;
            got[E02] = o_m02;
            got[E10] = o_m10;
            got[E11] = o_m11;
            got[E12] = o_m12;
            got[E20] = o_m20;
            got[E21] = o_m21;
            got[E22] = o_m22;
            if (rot_q.size() == 0) begin
                $error("matrix word with nothing outstanding");
                errors++;
            end else begin
                want = rot_q.pop_front();
                for (int i = 0; i < N_ENT; i++) begin
                    if (got[i] !== want[i]) begin
                        $error("%s: expected %0d, got %0d", ENT_NAME[i],
                               $signed(want[i]), $signed(got[i]));
                        errors++;
                    end
                end
            end
        end
        if (taken) rot_q.push_back(rotation_of(i_qx, i_qy, i_qz, i_qw));
        if (i_rst_n) begin
            if (taken || o_valid) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_quat_word rq;
        // zero quaternion gives the identity
        push_quat(0, 0, 0, 0);
        push_quat(0, 0, 0, 16384);
        push_quat(0, 0, 0, -16384);
        push_quat(16384, 0, 0, 0);
        push_quat(0, 16384, 0, 0);
        push_quat(0, 0, 16384, 0);
        push_quat(32767, 32767, 32767, 32767);
        push_quat(-32768, -32768, -32768, -32768);
        push_quat(32767, -32768, 32767, -32768);
        push_quat(-32768, 0, 0, 0);
        push_quat(0, 0, 0, 32767);
        // tiny, non-unit magnitudes
        push_quat(0, 0, 0, 1);
        push_quat(1, 0, 0, 0);
        push_quat(-1, 0, 0, 0);
        push_quat(1, 1, 1, 1);
        push_quat(-1, 1, -1, 1);
        push_quat(8192, 8192, 8192, 8192);
        push_quat(11585, 0, 0, 11585);
        push_quat(0, 11585, 0, -11585);
        push_quat(0, 0, -11585, 11585);
        push_quat(3, -5, 7, 2);
        push_quat(32767, 1, -1, 0);
        push_quat(-21846, 21845, 5461, -1);
        for (int i = 0; i < N_RANDOM; i++) begin
            rq = random_quat();
            rq.drain = (i == 0) || ($urandom_range(0, 149) == 0);
            quat_q.push_back(rq);
        end
        new_burst();
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (quat_q.size() != 0 || start || rot_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (rot_q.size() != 0) begin
            $error("%0d matrix words never arrived", rot_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### quaternion_to_rotation_matrix_core.f
+incdir+hw/rtl
hw/rtl/qrm_pkg.sv
hw/rtl/qrm_prod.sv
hw/rtl/qrm_recip.sv
hw/rtl/qrm_scale.sv
hw/rtl/quaternion_to_rotation_matrix_core.sv
sim/quaternion_to_rotation_matrix_core_tb.sv
